// File: sv/segment_fit_allocator_macros.svh
// assertion macros for the segment fit allocator checker
`ifndef SEGMENT_FIT_ALLOCATOR_MACROS_SVH
`define SEGMENT_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment fit allocator check failed");

// next-cycle implication
`define SFA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment fit allocator check failed");

`endif

// File: sv/sfa_pkg.sv
// shared types and codes of the segment fit allocator
`default_nettype none
package sfa_pkg;
  localparam int SEG_N  = 32;
  localparam int IDX_W  = $clog2(SEG_N);
  localparam int CNT_W  = $clog2(SEG_N + 1);
  localparam int ADDR_W = 16;

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
    logic              used;
  } seg_t;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic REG_STRATEGY = 1'b0;
  localparam logic REG_POOL     = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PICK  = 9'b000000010,
    S_FIND  = 9'b000000100,
    S_WRA   = 9'b000001000,
    S_WRB   = 9'b000010000,
    S_SHIFT = 9'b000100000,
    S_SPREP = 9'b001000000,
    S_STATS = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

// File: sv/segment_fit_allocator.sv
// segment fit allocator top level: segment table memory and command sequencer
//
// usage
//   commands enter on the s_axis channel: tuser carries cmd (0 alloc, 1 free,
//   2 query), tdata carries request_size and address. one result word leaves
//   on m_axis for every command, in order.
//   the apb port holds fit_strategy (address 0) and pool_size (address 4);
//   writing pool_size rebuilds the table as one free segment.
// command sequence (n = segment count)
//   every table scan issues n reads, then waits out the read latency and a drain.
//   a query is setup, statistics scan and result load; commands run one at a time.
//   an exact alloc adds a pick scan and a write; a free adds a find scan and a
//   write, and a merge also a shift of the moved entries; a split adds a pick
//   scan, a shift of the moved entries and two writes. the longest command is a
//   split at the head; the single read port sets this.
// reset
//   rst clears the controller; after reset (and after a pool_size write) entry 0
//   of the table is written before a command is taken.
// stalls
//   the result sits in an output register; the next command is accepted while
//   it waits, and the block holds before loading a second result.
`default_nettype none
module segment_fit_allocator import sfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size[15:0], address[31:16]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], block_offset[17:2], free_bytes[33:18], allocated_bytes[49:34],
  // largest_free[65:50], hole_count[71:66], small_free_count[77:72],
  // probe_allocated[78], zero fill [79]
  output logic [79:0] m_axis_tdata
);

  // configuration
  logic [1:0]        strategy;
  logic [ADDR_W-1:0] pool;
  logic              init_pend;

  // table bookkeeping
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] cursor;
  state_t           state;

  // latched command
  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] req_r;
  logic [ADDR_W-1:0] addr_r;

  // segment table memory
  seg_t             mem [SEG_N];
  seg_t             rdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  seg_t             wdata;

  // read sequencer shared by all scans and shifts
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rd_left;
  logic             rd_up;
  logic             rd_wrap;
  logic             dv;
  logic [IDX_W-1:0] dtag;
  logic             issue;
  logic             scan_done;
  logic [IDX_W-1:0] rd_ptr_next;

  // pick and find results
  logic             have;
  logic [IDX_W-1:0] fk;
  seg_t             fent;
  seg_t             prev;
  seg_t             nxt;
  seg_t             last;
  logic             need_next;
  logic             nxt_have;

  // pending writes
  seg_t             wa_e;
  seg_t             wb_e;
  logic [IDX_W-1:0] wb_i;
  logic [1:0]       sh_dist;
  logic             shift_after;

  // result accumulation
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] off_r;
  logic [ADDR_W-1:0] freeb;
  logic [ADDR_W-1:0] largest;
  logic [5:0]        holes;
  logic [5:0]        small_cnt;
  logic              probe;

  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_POOL) ? {16'b0, pool} : {30'b0, strategy};
  assign s_axis_tready = (state == S_IDLE) && !init_pend;

  // sequencer control
  assign issue     = ((state == S_PICK) || (state == S_FIND) || (state == S_STATS) ||
                      (state == S_SHIFT)) && (rd_left != '0);
  assign scan_done = (rd_left == '0) && !dv;

  always_comb begin
    if (rd_up) begin
      rd_ptr_next = rd_ptr - 1'b1;
    end else if (rd_wrap && ({1'b0, rd_ptr} + 1'b1 == cnt)) begin
      rd_ptr_next = '0;
    end else begin
      rd_ptr_next = rd_ptr + 1'b1;
    end
  end

  // write port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == S_IDLE && init_pend) begin
      we    = 1'b1;
      wdata = '{off: '0, size: pool, used: 1'b0};
    end else if (state == S_SHIFT && dv) begin
      we    = 1'b1;
      waddr = rd_up ? IDX_W'(dtag + 1'b1) : IDX_W'(dtag - IDX_W'(sh_dist));
      wdata = rdata;
    end else if (state == S_WRA) begin
      we    = 1'b1;
      waddr = IDX_W'(fk + 1'b1);
      wdata = wa_e;
    end else if (state == S_WRB) begin
      we    = 1'b1;
      waddr = wb_i;
      wdata = wb_e;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_ptr];
  end

  // candidate test during the pick scan
  logic pk_fits;
  logic pk_cand;
  always_comb begin
    pk_fits = !rdata.used && (rdata.size >= req_r);
    unique case (strategy)
      FIT_BEST:  pk_cand = pk_fits && (!have || rdata.size < fent.size);
      FIT_WORST: pk_cand = !rdata.used && (!have || rdata.size > fent.size);
      default:   pk_cand = pk_fits && !have;
    endcase
  end

  // alloc decision terms
  logic             al_ok;
  logic [IDX_W-1:0] al_start;
  logic [IDX_W-1:0] al_cur_exact;
  always_comb begin
    al_ok        = have && ((strategy != FIT_WORST) || (fent.size >= req_r));
    al_start     = ({1'b0, cursor} < cnt) ? cursor : '0;
    al_cur_exact = ({1'b0, fk} + 1'b1 < cnt) ? IDX_W'(fk + 1'b1) : '0;
  end

  // free decision terms: merge with free neighbours
  logic             fr_pf;
  logic             fr_nf;
  logic [IDX_W-1:0] fr_base;
  logic [ADDR_W-1:0] fr_size;
  logic [1:0]       fr_r;
  logic [CNT_W-1:0] fr_rem;
  logic [IDX_W-1:0] fr_src;
  logic [IDX_W-1:0] fr_c1;
  logic [IDX_W-1:0] fr_c2;
  always_comb begin
    fr_pf   = (fk != '0) && !prev.used;
    fr_nf   = nxt_have && !nxt.used;
    fr_base = fr_pf ? IDX_W'(fk - 1'b1) : fk;
    fr_size = fent.size + (fr_pf ? prev.size : '0) + (fr_nf ? nxt.size : '0);
    fr_r    = {1'b0, fr_pf} + {1'b0, fr_nf};
    fr_rem  = (fr_r == 2'd0) ? '0 :
              CNT_W'(cnt - {1'b0, fk} - CNT_W'(1) - CNT_W'(fr_nf));
    fr_src  = IDX_W'(fk + 1'b1 + IDX_W'(fr_nf));
    fr_c1   = (fr_pf && cursor >= fk) ? IDX_W'(cursor - 1'b1) : cursor;
    fr_c2   = (fr_nf && fr_c1 >= IDX_W'(fr_base + 1'b1)) ? IDX_W'(fr_c1 - 1'b1) : fr_c1;
  end

  logic load_out;
  assign load_out = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      init_pend     <= 1'b1;
      strategy      <= FIT_FIRST;
      pool          <= 16'hFFFF;
      cnt           <= CNT_W'(1);
      cursor        <= '0;
      dv            <= 1'b0;
      rd_left       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      dv   <= issue;
      dtag <= rd_ptr;
      if (issue) begin
        rd_left <= rd_left - 1'b1;
        rd_ptr  <= rd_ptr_next;
      end

      unique case (state)
        S_IDLE: begin
          if (init_pend) begin
            cnt       <= CNT_W'(1);
            cursor    <= '0;
            init_pend <= 1'b0;
          end else if (s_axis_tvalid) begin
            cmd_r     <= s_axis_tuser;
            req_r     <= s_axis_tdata[15:0];
            addr_r    <= s_axis_tdata[31:16];
            off_r     <= '0;
            have      <= 1'b0;
            need_next <= 1'b0;
            nxt_have  <= 1'b0;
            rd_up     <= 1'b0;
            rd_left   <= cnt;
            priority if (s_axis_tuser == CMD_ALLOC && s_axis_tdata[15:0] != '0) begin
              rd_ptr   <= (strategy == FIT_NEXT) ? al_start : '0;
              rd_wrap  <= (strategy == FIT_NEXT);
              state    <= S_PICK;
            end else if (s_axis_tuser == CMD_FREE) begin
              rd_ptr   <= '0;
              rd_wrap  <= 1'b0;
              state    <= S_FIND;
            end else if (s_axis_tuser == CMD_QUERY) begin
              status_r <= ST_OK;
              state    <= S_SPREP;
            end else begin
              // zero-size alloc or unknown command
              status_r <= ST_BAD;
              state    <= S_SPREP;
            end
          end
        end

        S_PICK: begin
          if (dv && pk_cand) begin
            have <= 1'b1;
            fk   <= dtag;
            fent <= rdata;
          end
          if (scan_done) begin
            shift_after <= 1'b0;
            priority if (!al_ok) begin
              status_r <= ST_NOFIT;
              state    <= S_SPREP;
            end else if (fent.size > req_r) begin
              if (cnt == CNT_W'(SEG_N)) begin
                status_r <= ST_FULL;
                state    <= S_SPREP;
              end else begin
                // split: open a slot after fk, then write remainder and head
                status_r <= ST_OK;
                off_r    <= fent.off;
                rd_ptr   <= IDX_W'(cnt - 1'b1);
                rd_left  <= CNT_W'(cnt - CNT_W'(1) - {1'b0, fk});
                rd_up    <= 1'b1;
                rd_wrap  <= 1'b0;
                wa_e     <= '{off: fent.off + req_r, size: fent.size - req_r, used: 1'b0};
                wb_e     <= '{off: fent.off, size: req_r, used: 1'b1};
                wb_i     <= fk;
                cnt      <= cnt + 1'b1;
                cursor   <= IDX_W'(fk + 1'b1);
                state    <= S_SHIFT;
              end
            end else begin
              status_r <= ST_OK;
              off_r    <= fent.off;
              wb_e     <= '{off: fent.off, size: fent.size, used: 1'b1};
              wb_i     <= fk;
              cursor   <= al_cur_exact;
              state    <= S_WRB;
            end
          end
        end

        S_FIND: begin
          if (dv) begin
            last <= rdata;
            if (!have && rdata.off == addr_r) begin
              have      <= 1'b1;
              fk        <= dtag;
              fent      <= rdata;
              prev      <= last;
              need_next <= 1'b1;
            end else if (need_next) begin
              nxt       <= rdata;
              nxt_have  <= 1'b1;
              need_next <= 1'b0;
            end
          end
          if (scan_done) begin
            if (!have || !fent.used) begin
              status_r <= ST_BAD;
              state    <= S_SPREP;
            end else begin
              status_r    <= ST_OK;
              wb_e        <= '{off: fr_pf ? prev.off : fent.off, size: fr_size, used: 1'b0};
              wb_i        <= fr_base;
              rd_ptr      <= fr_src;
              rd_left     <= fr_rem;
              rd_up       <= 1'b0;
              rd_wrap     <= 1'b0;
              sh_dist     <= fr_r;
              cnt         <= CNT_W'(cnt - CNT_W'(fr_r));
              cursor      <= fr_c2;
              shift_after <= 1'b1;
              state       <= S_WRB;
            end
          end
        end

        S_SHIFT: begin
          if (scan_done) begin
            state <= rd_up ? S_WRA : S_SPREP;
          end
        end

        S_WRA: begin
          state <= S_WRB;
        end

        S_WRB: begin
          state <= shift_after ? S_SHIFT : S_SPREP;
        end

        S_SPREP: begin
          rd_ptr    <= '0;
          rd_left   <= cnt;
          rd_up     <= 1'b0;
          rd_wrap   <= 1'b0;
          freeb     <= '0;
          largest   <= '0;
          holes     <= '0;
          small_cnt <= '0;
          probe     <= 1'b0;
          state     <= S_STATS;
        end

        S_STATS: begin
          if (dv) begin
            if (!rdata.used) begin
              freeb <= freeb + rdata.size;
              holes <= holes + 1'b1;
              if (rdata.size > largest) begin
                largest <= rdata.size;
              end
              if (rdata.size <= req_r) begin
                small_cnt <= small_cnt + 1'b1;
              end
            end
            // offsets rise, so the last entry at or below address holds it
            if (dtag == '0 || rdata.off <= addr_r) begin
              probe <= rdata.used;
            end
          end
          if (scan_done) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // configuration writes must arrive only while idle; the block itself does not enforce this
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_POOL) begin
          pool      <= pwdata[15:0];
          init_pend <= 1'b1;
        end else begin
          strategy  <= pwdata[1:0];
        end
      end
    end
  end

  // output word register, payload only
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {1'b0,
                       (cmd_r == CMD_QUERY) ? probe : 1'b0,
                       (cmd_r == CMD_QUERY) ? small_cnt : 6'd0,
                       holes,
                       largest,
                       pool - freeb,
                       freeb,
                       off_r,
                       status_r};
    end
  end

endmodule
`default_nettype wire

// File: sv/sfa_checker.sv
// port-level checker for the segment fit allocator, bound to the top level
`default_nettype none
`include "segment_fit_allocator_macros.svh"
module sfa_checker import sfa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // a held result word does not change
  `SFA_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a command that does not succeed reports a zero offset
  `SFA_ASSERT_IMP(a_off, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK, m_axis_tdata[17:2] == 16'd0)
  // the largest hole cannot exceed total free bytes
  `SFA_ASSERT_IMP(a_largest, m_axis_tvalid, m_axis_tdata[65:50] <= m_axis_tdata[33:18])
  // small holes are a subset of all holes, which never exceed the table
  `SFA_ASSERT_IMP(a_holes, m_axis_tvalid,
                  m_axis_tdata[77:72] <= m_axis_tdata[71:66] && m_axis_tdata[71:66] <= 6'd32)

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
